FILE: design/dbc_pkg.sv
// Package for the disk block cache tag unit: sizes, payload words and derived constants.
// Used by dbc_front, dbc_back, dbc_resq and disk_block_cache_lru_tags; depends on nothing.
package dbc_pkg;

	localparam int ENTRIES       = 8;
	localparam int ENTRY_SECTORS = 8;
	localparam int SECTOR_BYTES  = 512;

	localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ALIGN_SHIFT = $clog2(SECTOR_BYTES * ENTRY_SECTORS);
	localparam int SEC_SHIFT   = $clog2(ENTRY_SECTORS);

	typedef struct packed {
		logic [7:0]  disk_number;
		logic [31:0] byte_address;
		logic [31:0] wanted_end_sector;
	} dbc_req_t;

	typedef struct packed {
		logic [2:0]  entry_index;
		logic        hit;
		logic [31:0] fetch_start_sector;
		logic [3:0]  fetch_count;
		logic [3:0]  buffer_offset_sectors;
	} dbc_res_t;

	// Classified request as it waits between the front and the back.
	typedef struct packed {
		logic [7:0]  disk;
		logic [31:0] aligned;
		logic [31:0] wanted;
	} dbc_cmd_t;

endpackage

FILE: design/dbc_front.sv
// Front part of the disk block cache tag unit: accepts request words, computes the
// aligned entry start and holds up to two classified requests. Depends on dbc_pkg.
module dbc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  dbc_pkg::dbc_req_t request,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output dbc_pkg::dbc_cmd_t cmd
);

	dbc_pkg::dbc_cmd_t slot_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	dbc_pkg::dbc_cmd_t cls;
	logic              do_push;
	logic              do_pop;

	// The entry start is the request sector rounded down to a whole entry.
	always_comb begin
		cls.disk    = request.disk_number;
		cls.aligned = 32'((request.byte_address >> dbc_pkg::ALIGN_SHIFT) << dbc_pkg::SEC_SHIFT);
		cls.wanted  = request.wanted_end_sector;
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: design/dbc_resq.sv
// Result queue of the disk block cache tag unit: two result words toward the consumer.
// Depends on dbc_pkg.
module dbc_resq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_push,
	input  dbc_pkg::dbc_res_t res_in,
	output logic              res_full,
	output logic              empty,
	input  logic              pop,
	output dbc_pkg::dbc_res_t result
);

	dbc_pkg::dbc_res_t slot_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              do_push;
	logic              do_pop;

	assign res_full = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign result   = slot_q[rd_ptr_q];
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: design/dbc_back.sv
// Back part of the disk block cache tag unit: holds the tag store, scans it one entry a
// cycle for a match and the oldest stamp, then clamps, fills and stamps. Depends on dbc_pkg.
module dbc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  dbc_pkg::dbc_cmd_t cmd,
	output logic              res_push,
	input  logic              res_full,
	output dbc_pkg::dbc_res_t res_out
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_CLAMP  = 4'b0100,
		ST_COMMIT = 4'b1000
	} dbc_state_t;

	localparam logic [dbc_pkg::IDX_W-1:0] LAST_IDX = dbc_pkg::IDX_W'(dbc_pkg::ENTRIES - 1);

	dbc_state_t state_q;

	logic [7:0]  tag_q       [dbc_pkg::ENTRIES];
	logic [31:0] start_q     [dbc_pkg::ENTRIES];
	logic [31:0] filled_q    [dbc_pkg::ENTRIES];
	logic [31:0] stamp_q     [dbc_pkg::ENTRIES];
	logic [31:0] stamp_cnt_q;

	dbc_pkg::dbc_cmd_t         cmd_q;
	logic [dbc_pkg::IDX_W-1:0] idx_q;
	logic [dbc_pkg::IDX_W-1:0] victim_q;
	logic [dbc_pkg::IDX_W-1:0] hit_idx_q;
	logic [dbc_pkg::IDX_W-1:0] sel_q;
	logic [31:0]               min_q;
	logic                      hit_q;
	logic [31:0]               s_q;
	logic [31:0]               fe_q;
	logic [32:0]               end_q;

	logic [dbc_pkg::IDX_W-1:0] rd_idx;
	logic [7:0]                rd_tag;
	logic [31:0]               rd_start;
	logic [31:0]               rd_filled;
	logic [31:0]               rd_stamp;
	logic                      match;
	logic                      hit_n;
	logic [dbc_pkg::IDX_W-1:0] hit_idx_n;
	logic [dbc_pkg::IDX_W-1:0] victim_n;
	logic [31:0]               min_n;

	logic [31:0] s_c;
	logic [31:0] fe_c;
	logic [32:0] lim_c;
	logic [32:0] low_c;
	logic [32:0] end_c;

	logic        fetch;
	logic [32:0] count_c;
	logic [31:0] off_c;
	logic [31:0] cnt_inc;
	logic        commit;

	// One read port into the tag store: the scan position, or the chosen entry afterwards.
	assign rd_idx    = (state_q == ST_SCAN) ? idx_q : sel_q;
	assign rd_tag    = tag_q[rd_idx];
	assign rd_start  = start_q[rd_idx];
	assign rd_filled = filled_q[rd_idx];
	assign rd_stamp  = stamp_q[rd_idx];

	always_comb begin
		match     = (rd_tag == cmd_q.disk) && (rd_start == cmd_q.aligned);
		hit_n     = hit_q;
		hit_idx_n = hit_idx_q;
		if (!hit_q && match) begin
			hit_n     = 1'b1;
			hit_idx_n = idx_q;
		end
		// Strict less-than keeps the lowest index among equal stamps.
		victim_n = victim_q;
		min_n    = min_q;
		if (idx_q == '0 || rd_stamp < min_q) begin
			victim_n = idx_q;
			min_n    = rd_stamp;
		end
	end

	// A missed entry is rebuilt empty at the aligned start.
	always_comb begin
		s_c   = hit_q ? rd_start : cmd_q.aligned;
		fe_c  = hit_q ? rd_filled : cmd_q.aligned;
		lim_c = {1'b0, s_c} + 33'(dbc_pkg::ENTRY_SECTORS);
		low_c = (cmd_q.wanted < s_c) ? {1'b0, s_c} : {1'b0, cmd_q.wanted};
		end_c = (low_c > lim_c) ? lim_c : low_c;
	end

	always_comb begin
		fetch   = end_q > {1'b0, fe_q};
		count_c = end_q - {1'b0, fe_q};
		off_c   = fe_q - s_q;
		cnt_inc = stamp_cnt_q + 32'd1;
		commit  = (state_q == ST_COMMIT) && !res_full;

		res_out.entry_index           = 3'(sel_q);
		res_out.hit                   = hit_q;
		res_out.fetch_start_sector    = fetch ? fe_q : 32'd0;
		res_out.fetch_count           = fetch ? 4'(count_c) : 4'd0;
		res_out.buffer_offset_sectors = fetch ? 4'(off_c) : 4'd0;
	end

	assign cmd_ready = (state_q == ST_IDLE);
	assign res_push  = commit;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_q <= cmd;
				end
			end
			ST_SCAN: begin
				if (idx_q == LAST_IDX) begin
					sel_q <= hit_n ? hit_idx_n : victim_n;
				end
			end
			ST_CLAMP: begin
				s_q   <= s_c;
				fe_q  <= fe_c;
				end_q <= end_c;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			victim_q    <= '0;
			hit_idx_q   <= '0;
			min_q       <= 32'd0;
			hit_q       <= 1'b0;
			stamp_cnt_q <= 32'd0;
			for (int i = 0; i < dbc_pkg::ENTRIES; i++) begin
				tag_q[i]    <= 8'd0;
				start_q[i]  <= 32'd0;
				filled_q[i] <= 32'd0;
				stamp_q[i]  <= 32'd0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						idx_q   <= '0;
						hit_q   <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					hit_q     <= hit_n;
					hit_idx_q <= hit_idx_n;
					victim_q  <= victim_n;
					min_q     <= min_n;
					if (idx_q == LAST_IDX) begin
						state_q <= ST_CLAMP;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_CLAMP: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (commit) begin
						tag_q[sel_q]    <= cmd_q.disk;
						start_q[sel_q]  <= s_q;
						filled_q[sel_q] <= fetch ? end_q[31:0] : fe_q;
						// Reaching all ones wipes every stamp, the fresh one too.
						if (cnt_inc == '1) begin
							stamp_cnt_q <= 32'd0;
							for (int i = 0; i < dbc_pkg::ENTRIES; i++) begin
								stamp_q[i] <= 32'd0;
							end
						end else begin
							stamp_cnt_q    <= cnt_inc;
							stamp_q[sel_q] <= stamp_cnt_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: design/disk_block_cache_lru_tags.sv
// Disk block cache tag unit, fully associative with least-recently-used replacement.
// The back takes a new word only once it has committed the last one: it takes the word,
// scans the tag store one entry a cycle, clamps the wanted end and commits the result,
// waiting in its commit step while the result queue is full.
// Reset: arst_n clears all tags, starts, filled ends, stamps, the stamp counter and queues.
module disk_block_cache_lru_tags (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  dbc_pkg::dbc_req_t request,
	output logic              empty,
	input  logic              pop,
	output dbc_pkg::dbc_res_t result
);

	// The front turns each request word into a disk number, an entry-aligned start
	// sector and the wanted end, and keeps two of them so that the caller can push
	// the next request while the back is still scanning.
	logic              cmd_valid;
	logic              cmd_ready;
	dbc_pkg::dbc_cmd_t cmd;

	// Between the back and the result queue.
	logic              res_push;
	logic              res_full;
	dbc_pkg::dbc_res_t res_word;

	dbc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.request   (request),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// The back owns the tag store. It searches for the first entry whose disk and
	// start match and, in the same pass, for the entry with the smallest stamp. It then
	// clamps the wanted end into the entry, works out the sectors still to read, and
	// stamps the chosen entry. It waits in its commit step while the result queue is full,
	// so no state changes until the result word has a place to go.
	dbc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_push  (res_push),
		.res_full  (res_full),
		.res_out   (res_word)
	);

	// The result queue lets a finished word wait for pop without holding the back.
	dbc_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res_word),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

	// When nothing is fetched, the start and offset of the word are zero.
	a_no_fetch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.fetch_count == 4'd0) |->
		(result.fetch_start_sector == 32'd0 && result.buffer_offset_sectors == 4'd0))
		else $error("empty fetch carries a nonzero start or offset");

	// A fetch never reaches past the end of the entry buffer.
	a_fetch_in_entry: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |->
		(({1'b0, result.buffer_offset_sectors} + {1'b0, result.fetch_count})
			<= 5'(dbc_pkg::ENTRY_SECTORS)))
		else $error("fetch runs past the entry buffer");

	// The selected entry always exists.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (32'(result.entry_index) < 32'(dbc_pkg::ENTRIES)))
		else $error("entry index out of range");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for disk_block_cache_lru_tags: directed and random disk read requests, checked
// against a scoreboard that keeps its own copy of the tags, fill marks and use stamps.
// Depends on dbc_pkg for the request and result words and the cache geometry.
module tb;

	localparam int RANDOM_REQUESTS = 1530;
	// A correct run never goes this long without a handshake on either side.
	localparam int WATCHDOG_LIMIT  = 2000;
	// Long enough for a stray word to show up after the last expected one.
	localparam int DRAIN_CYCLES    = 48;
	localparam int DISK_POOL       = 3;
	localparam int BLOCK_POOL      = 10;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              push    = 1'b0;
	logic              pop     = 1'b0;
	dbc_pkg::dbc_req_t request = '0;
	logic              full;
	logic              empty;
	dbc_pkg::dbc_res_t result;

	// While one of these is set, its side of the unit never idles.
	bit sender_steady   = 1'b0;
	bit receiver_steady = 1'b0;

	// The scoreboard mirrors the tag store. Each accepted request is resolved at once against
	// the mirror, and the outcome waits in a queue until the unit hands over its result word.
	class dbc_scoreboard;
		logic [7:0]        tag_disk [dbc_pkg::ENTRIES];
		logic [31:0]       start_sector [dbc_pkg::ENTRIES];
		logic [31:0]       filled_end [dbc_pkg::ENTRIES];
		logic [31:0]       use_stamp [dbc_pkg::ENTRIES];
		logic [31:0]       stamp_counter;
		dbc_pkg::dbc_res_t pending_lookups[$];
		int                errors;
		int                checked;

		function new();
			foreach (tag_disk[k]) begin
				tag_disk[k]     = '0;
				start_sector[k] = '0;
				filled_end[k]   = '0;
				use_stamp[k]    = '0;
			end
			stamp_counter = '0;
			errors        = 0;
			checked       = 0;
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		// Look the request up, pick the entry, stamp it and work out what must still be read.
		function void note_request(dbc_pkg::dbc_req_t req);
			dbc_pkg::dbc_res_t res;
			int                victim;
			int                sel;
			bit                found;
			logic [31:0]       aligned;
			logic [32:0]       s;
			logic [32:0]       fe;
			logic [32:0]       lim;
			logic [32:0]       want_end;

			victim  = 0;
			sel     = 0;
			found   = 1'b0;
			aligned = (req.byte_address >> dbc_pkg::ALIGN_SHIFT) << dbc_pkg::SEC_SHIFT;
			for (int k = 0; k < dbc_pkg::ENTRIES; k++) begin
				// Strict less-than keeps the lowest index when stamps tie.
				if (use_stamp[k] < use_stamp[victim])
					victim = k;
				if (!found && tag_disk[k] == req.disk_number && start_sector[k] == aligned) begin
					found = 1'b1;
					sel   = k;
				end
			end
			if (!found) begin
				sel               = victim;
				tag_disk[sel]     = req.disk_number;
				start_sector[sel] = aligned;
				filled_end[sel]   = aligned;
			end

			use_stamp[sel] = stamp_counter;
			stamp_counter  = stamp_counter + 1;
			if (stamp_counter == '1) begin
				foreach (use_stamp[k])
					use_stamp[k] = '0;
				stamp_counter = '0;
			end

			s   = {1'b0, start_sector[sel]};
			fe  = {1'b0, filled_end[sel]};
			lim = s + dbc_pkg::ENTRY_SECTORS;
			// The wanted end is pulled up to the entry start, then capped at the entry size.
			want_end = {1'b0, req.wanted_end_sector};
			if (want_end < s)
				want_end = s;
			if (want_end > lim)
				want_end = lim;

			res             = '0;
			res.entry_index = 3'(sel);
			res.hit         = found;
			if (want_end > fe) begin
				res.fetch_start_sector    = fe[31:0];
				res.fetch_count           = 4'(want_end - fe);
				res.buffer_offset_sectors = 4'(fe - s);
				filled_end[sel]           = want_end[31:0];
			end
			pending_lookups.push_back(res);
		endfunction

		task check_result(dbc_pkg::dbc_res_t got);
			dbc_pkg::dbc_res_t want;

			checked++;
			if (pending_lookups.size() == 0) begin
				report($sformatf("result %0d arrived with no request waiting", checked));
			end else begin
				want = pending_lookups.pop_front();
				if (got.entry_index !== want.entry_index)
					report($sformatf("result %0d: entry_index got %0d want %0d",
						checked, got.entry_index, want.entry_index));
				if (got.hit !== want.hit)
					report($sformatf("result %0d: hit got %0b want %0b",
						checked, got.hit, want.hit));
				if (got.fetch_start_sector !== want.fetch_start_sector)
					report($sformatf("result %0d: fetch_start_sector got %h want %h",
						checked, got.fetch_start_sector, want.fetch_start_sector));
				if (got.fetch_count !== want.fetch_count)
					report($sformatf("result %0d: fetch_count got %0d want %0d",
						checked, got.fetch_count, want.fetch_count));
				if (got.buffer_offset_sectors !== want.buffer_offset_sectors)
					report($sformatf("result %0d: buffer_offset_sectors got %0d want %0d",
						checked, got.buffer_offset_sectors, want.buffer_offset_sectors));
			end
		endtask
	endclass

	dbc_scoreboard lookups;

	disk_block_cache_lru_tags dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.request (request),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Offer one request word after a random gap and hold it until the unit takes it. Signals
	// are sampled right after the edge, so they still hold the values the edge saw. When
	// the gap is zero, push simply stays high into the next word.
	task automatic send_request(dbc_pkg::dbc_req_t req);
		int gap;

		gap = sender_steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push    <= 1'b1;
		request <= req;
		@(posedge clk);
		while (full)
			@(posedge clk);
		lookups.note_request(req);
	endtask

	// Result side: wait a random number of cycles before each word, then pop until one is taken.
	initial begin
		int delay;
		int taken;

		taken = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			delay = receiver_steady ? 0 : $urandom_range(0, 7);
			if (delay > 0) begin
				pop <= 1'b0;
				repeat (delay) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			lookups.check_result(result);
			taken++;
			if (taken % 64 == 0)
				receiver_steady = ($urandom_range(0, 3) == 0);
		end
	end

	// The run ends as a failure if no word moves on either side for too long.
	initial begin
		int idle_cycles;

		wait (arst_n === 1'b1);
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		logic [7:0]        disk_pool [DISK_POOL];
		logic [19:0]       block_pool [BLOCK_POOL];
		logic [7:0]        disk;
		logic [19:0]       blk;
		logic [31:0]       s;
		dbc_pkg::dbc_req_t req;

		lookups = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fresh entries hold disk 0 at sector 0: a request for disk 0 near address 0 hits
		// one, first with nothing wanted, then filled in two steps, then past the entry end.
		send_request('{8'h00, 32'h0000_0000, 32'h0000_0000});
		send_request('{8'h00, 32'h0000_0000, 32'h0000_0003});
		send_request('{8'h00, 32'h0000_0100, 32'h0000_0008});
		send_request('{8'h00, 32'h0000_0fff, 32'hffff_ffff});
		// First miss: every other stamp is still zero, so the lowest free index is replaced.
		send_request('{8'hff, 32'hffff_ffff, 32'hffff_ffff});
		// Wanted end below the entry start is raised to the start, so nothing is read.
		send_request('{8'hff, 32'hffff_f000, 32'h0000_0000});
		send_request('{8'h01, 32'h0000_2000, 32'h0000_0000});
		send_request('{8'h01, 32'h0000_2fff, 32'h0000_0011});
		send_request('{8'h01, 32'h0000_2800, 32'h0000_0015});
		send_request('{8'h01, 32'h0000_2400, 32'h0000_0014});
		send_request('{8'h55, 32'haaaa_aaaa, 32'h5555_5555});
		send_request('{8'haa, 32'h5555_5555, 32'haaaa_aaaa});
		// Fill the rest of the store, then keep going so that least-recent entries are evicted.
		send_request('{8'h02, 32'h0001_0000, 32'h0000_0084});
		send_request('{8'h03, 32'h0002_0000, 32'h0000_0107});
		send_request('{8'h04, 32'h0003_0000, 32'h0000_0188});
		send_request('{8'h05, 32'h0004_0000, 32'h0000_0201});
		send_request('{8'h06, 32'h0005_0000, 32'h0000_0282});
		send_request('{8'h07, 32'h0006_0000, 32'h0000_0300});
		// The disk 0 entry was used long ago; a new disk at address 0 must not hit it.
		send_request('{8'h08, 32'h0000_0000, 32'h0000_0005});
		send_request('{8'h00, 32'h0000_0000, 32'h0000_0008});
		send_request('{8'hff, 32'hffff_f800, 32'hffff_fffe});
		send_request('{8'h01, 32'h0000_2000, 32'h0000_0018});

		// Random part. Most requests reuse a small pool of disks and blocks so that hits,
		// step-by-step fills and evictions all happen; the rest are fully random words.
		disk = '0;
		blk  = '0;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 250 == 0) begin
				foreach (disk_pool[i])
					disk_pool[i] = 8'($urandom);
				foreach (block_pool[i])
					block_pool[i] = 20'($urandom);
			end
			if (n % 64 == 0)
				sender_steady = ($urandom_range(0, 3) == 0);

			if ($urandom_range(0, 4) == 0) begin
				req.disk_number       = 8'($urandom);
				req.byte_address      = $urandom;
				req.wanted_end_sector = $urandom;
			end else begin
				// Half of the pooled requests go back to the block just used.
				if ($urandom_range(0, 1) == 0) begin
					disk = disk_pool[$urandom_range(0, DISK_POOL - 1)];
					blk  = block_pool[$urandom_range(0, BLOCK_POOL - 1)];
				end
				s = {9'b0, blk, 3'b0};
				req.disk_number  = disk;
				req.byte_address = {blk, 12'($urandom)};
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: req.wanted_end_sector = s + $urandom_range(0, 9);
					6:       req.wanted_end_sector = s - $urandom_range(1, 8);
					7:       req.wanted_end_sector = $urandom;
					8:       req.wanted_end_sector = 32'hffff_ffff - $urandom_range(0, 3);
					default: req.wanted_end_sector = s;
				endcase
			end
			send_request(req);
		end
		push <= 1'b0;

		while (lookups.pending_lookups.size() != 0)
			@(posedge clk);
		// Give any word the unit should not have produced time to show up.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (lookups.pending_lookups.size() != 0)
			lookups.report($sformatf("%0d results never arrived",
				lookups.pending_lookups.size()));

		if (lookups.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
